// ===== hdl/olam_pkg.sv =====
// Package with shared widths, operation and status codes, and the cell control struct.
`timescale 1ns / 1ps

package olam_pkg;

  // Fixed field widths of the input and result words.
  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;
  localparam int LEN_W = 5;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] STS_APPENDED = 3'd0;
  localparam logic [ST_W-1:0] STS_FULL     = 3'd1;
  localparam logic [ST_W-1:0] STS_REMOVED  = 3'd2;
  localparam logic [ST_W-1:0] STS_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] STS_CLEARED  = 3'd4;
  localparam logic [ST_W-1:0] STS_INVALID  = 3'd5;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    logic append;  // write the append data into the cell at the current count
    logic live;    // the scan token is still inside the occupied part of the list
  } cell_ctl_t;

endpackage

// ===== hdl/olam_if.sv =====
// Valid/ready channel interfaces for the input word and the result word.
`timescale 1ns / 1ps

interface olam_in_if;
  import olam_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [VAL_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface olam_out_if;
  import olam_pkg::*;

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [LEN_W-1:0] length;

  modport source (output valid, output status, output length, input ready);
  modport sink (input valid, input status, input length, output ready);
endinterface

// ===== hdl/olam_cell.sv =====
// One list cell: holds an entry, takes appends and passes the scan token to its neighbor.
`timescale 1ns / 1ps

module olam_cell #(
  parameter int ELEM_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  olam_pkg::cell_ctl_t   ctl,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [ELEM_WIDTH-1:0] wr_data,
  input  logic [ELEM_WIDTH-1:0] key,
  input  logic [ELEM_WIDTH-1:0] next_entry,
  input  logic                  tok_in,
  input  logic                  shf_in,
  output logic [ELEM_WIDTH-1:0] entry_o,
  output logic                  tok_o,
  output logic                  shf_o
);
  import olam_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [ELEM_WIDTH-1:0] entry_r, entry_nxt;
  logic                  tok_r;
  logic                  shf_r;
  logic                  hit;

  // A searching token that finds its key turns into a shifting token here.
  assign hit = tok_r && !shf_r && ctl.live && (entry_r == key);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.append && (count_i == MY_IDX)) begin
      entry_nxt = wr_data;
    end else if (tok_r && (shf_r || hit)) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      shf_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
      shf_r <= shf_in;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign tok_o   = tok_r;
  assign shf_o   = shf_r || hit;

endmodule

// ===== hdl/olam_ctrl.sv =====
// Controller: handshakes, fill count, remove sequencing and the result register.
`timescale 1ns / 1ps

module olam_ctrl #(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  olam_in_if.sink               in_ch,
  olam_out_if.source            out_ch,
  output olam_pkg::cell_ctl_t   ctl,
  output logic [CNT_W-1:0]      count_o,
  output logic [ELEM_WIDTH-1:0] wr_data,
  output logic [ELEM_WIDTH-1:0] key,
  output logic                  start_tok,
  input  logic                  last_tok,
  input  logic                  last_shf
);
  import olam_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [ELEM_WIDTH-1:0] key_r, key_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]       status_r, status_nxt;
  logic [LEN_W-1:0]      length_r, length_nxt;
  logic [VAL_W+63:0]     val_ext;
  logic                  fire;
  logic                  out_free;
  logic                  load;
  logic                  append;

  function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] c);
    logic [CNT_W+LEN_W-1:0] e;
    e = {{LEN_W{1'b0}}, c};
    return e[LEN_W-1:0];
  endfunction

  assign val_ext  = {64'd0, in_ch.value};
  assign wr_data  = val_ext[ELEM_WIDTH-1:0];
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    length_nxt    = length_r;
    load          = 1'b0;
    append        = 1'b0;
    start_tok     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          case (in_ch.op)
            OP_APPEND: begin
              load = 1'b1;
              if (count_r < CNT_W'(DEPTH)) begin
                append     = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
                status_nxt = STS_APPENDED;
              end else begin
                status_nxt = STS_FULL;
              end
            end
            OP_REMOVE: begin
              key_nxt   = wr_data;
              idx_nxt   = '0;
              start_tok = 1'b1;
              state_nxt = S_SCAN;
            end
            OP_CLEAR: begin
              load       = 1'b1;
              count_nxt  = '0;
              status_nxt = STS_CLEARED;
            end
            default: begin
              load       = 1'b1;
              status_nxt = STS_INVALID;
            end
          endcase
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (last_tok) begin
          found_nxt = last_shf;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (out_free) begin
          load       = 1'b1;
          state_nxt  = S_IDLE;
          if (found_r) begin
            count_nxt  = count_r - CNT_W'(1);
            status_nxt = STS_REMOVED;
          end else begin
            status_nxt = STS_NOTFOUND;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
      length_nxt    = len_of(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    key_r    <= key_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    length_r <= length_nxt;
  end

  assign ctl.append = append;
  assign ctl.live   = (state_r == S_SCAN) && (CNT_W'(idx_r) < count_r);
  assign count_o    = count_r;
  assign key        = key_r;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.length = length_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("input accepted during a remove");

  a_post_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POST && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("remove result not delivered");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POST && out_free && found_r) |=>
      (count_r == $past(count_r) - CNT_W'(1)))
    else $error("successful remove did not shorten the list");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(status_r)))
    else $error("stalled result changed");
`endif

endmodule

// ===== hdl/ordered_list_append_remove_match_top.sv =====
// Top level of the ordered list with append, remove-first-match and clear.
// The list is a row of DEPTH cells, each holding one entry. For append, clear
// and an unknown operation the word is accepted and its result is in the
// output register at the next edge, and a new word is taken as soon as that
// register is free or being emptied. A remove is a scan: a token enters the
// first cell the cycle after acceptance and walks one cell per cycle to the
// end of the row, comparing each entry against the key; at the first match
// it starts to pull every later entry one slot forward, cell by cell, and the
// controller reports the outcome once the token leaves the last cell and the
// output register is free. No word is accepted while a remove is walking the
// row. Entries at or beyond the fill count hold stale data and are never
// compared. The length field reports the fill count after the step,
// truncated to five bits when DEPTH exceeds 31.
`timescale 1ns / 1ps

module ordered_list_append_remove_match_top #(
  parameter int DEPTH      = olam_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = olam_pkg::ELEM_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  olam_in_if.sink    in_ch,
  olam_out_if.source out_ch
);
  import olam_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_ctl_t             ctl;
  logic [CNT_W-1:0]      count;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic [ELEM_WIDTH-1:0] key;
  logic                  start_tok;

  // Per-cell signals; index i is cell i, the head of the list is cell 0.
  logic [ELEM_WIDTH-1:0] entry [DEPTH];
  logic [ELEM_WIDTH-1:0] next_entry [DEPTH];
  logic [DEPTH-1:0]      tok;
  logic [DEPTH-1:0]      shf;
  logic [DEPTH-1:0]      tok_in;
  logic [DEPTH-1:0]      shf_in;

  olam_ctrl #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ctl       (ctl),
    .count_o   (count),
    .wr_data   (wr_data),
    .key       (key),
    .start_tok (start_tok),
    .last_tok  (tok[DEPTH-1]),
    .last_shf  (shf[DEPTH-1])
  );

  // The token enters at the head in search mode and ripples toward the tail.
  assign tok_in = {tok[DEPTH-2:0], start_tok};
  assign shf_in = {shf[DEPTH-2:0], 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // The tail cell has no neighbor; what it pulls in lies beyond the count.
    if (i == DEPTH - 1) begin : g_tail
      assign next_entry[i] = entry[i];
    end else begin : g_body
      assign next_entry[i] = entry[i+1];
    end

    olam_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .count_i    (count),
      .wr_data    (wr_data),
      .key        (key),
      .next_entry (next_entry[i]),
      .tok_in     (tok_in[i]),
      .shf_in     (shf_in[i]),
      .entry_o    (entry[i]),
      .tok_o      (tok[i]),
      .shf_o      (shf[i])
    );
  end

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok))
    else $error("more than one scan token in the row");

  a_token_enters: assert property (@(posedge clk) disable iff (!rst_n)
    start_tok |=> (tok[0] && !shf[DEPTH-1] || tok[0]))
    else $error("scan token did not enter the head cell");

  a_no_append_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (|tok) |-> !ctl.append)
    else $error("append during a scan");
`endif

endmodule
